@@ rtl/assert_macros.svh @@
// Assertion macros used by the frame queue top level.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, checked outside reset
`define FBQM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fbqm check failed");
// same-cycle implication
`define FBQM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fbqm check failed");
// next-cycle implication
`define FBQM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fbqm check failed");
`else
`define FBQM_ASSERT(lbl, clk, rstn, prop)
`define FBQM_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define FBQM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/fbqm_pkg.sv @@
// Types and codes for the frame buffer queue manager.
// No dependencies; used by frame_buffer_queue_manager_top and the bench.
`default_nettype none

package fbqm_pkg;

  localparam int HANDLE_W = 16;
  localparam int COUNT_W = 4;
  localparam int TOTAL_W = 32;
  localparam int MAX_RESULTS = 8;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 4'd4;

  typedef enum logic [2:0] {
    OP_SUBMIT   = 3'd0,
    OP_ACQUIRE  = 3'd1,
    OP_LATEST   = 3'd2,
    OP_RELEASE  = 3'd3,
    OP_DELIVER  = 3'd4,
    OP_CLAIM    = 3'd5,
    OP_LISTENER = 3'd6,
    OP_CLOSE    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACK         = 3'd0,
    KIND_GRANTED     = 3'd1,
    KIND_HANDED_BACK = 3'd2,
    KIND_EMPTY       = 3'd3,
    KIND_AT_LIMIT    = 3'd4,
    KIND_CLAIM_YES   = 3'd5,
    KIND_CLAIM_NO    = 3'd6,
    KIND_FIRE        = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP_RD,
    ST_POP_OUT,
    ST_SINGLE
  } state_e;

  typedef struct packed {
    logic [2:0]          operation;
    logic [HANDLE_W-1:0] buffer_handle;
    logic                listener_on;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] out_handle;
    logic                notify_post;
    logic [COUNT_W-1:0]  queued_now;
    logic [COUNT_W-1:0]  promised_now;
    logic [COUNT_W-1:0]  held_now;
    logic [TOTAL_W-1:0]  submitted_total;
    logic [TOTAL_W-1:0]  dropped_total;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/fbqm_store.sv @@
// Handle store of the frame queue: one write port, one registered read port.
// Standalone; instantiated by frame_buffer_queue_manager_top.
`default_nettype none

module fbqm_store #(
  parameter int DEPTH  = 8,
  parameter int IDX_W  = 3,
  parameter int DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [IDX_W-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/frame_buffer_queue_manager_top.sv @@
// Frame buffer queue manager: command decode, sequencer and counters.
// Depends on fbqm_pkg, fbqm_store and assert_macros.svh.
//
// Usage:
//   A command word is taken on cmd_i at a rising edge where start is high and
//   busy is low. busy stays high until the last result word of that command
//   has been shown. Each result word is on result_o for one cycle, marked by
//   result_strobe_o; result_o.last flags the final word. The receiver cannot
//   stall, so every strobed word must be taken when shown.
//   A command that walks no entries shows its one result word in ST_SINGLE,
//   after ST_DECIDE; a new command is taken only once the block is back in
//   ST_IDLE. Acquire, latest acquire and close walk the queue through the
//   registered read port of the handle store, one entry at a time: ST_POP_RD
//   reads an entry and ST_POP_OUT shows it. The queue pointer arithmetic
//   (modular add) is one shared unit, used for the write slot, the new head and
//   the walk pointer in turn. image_limit is written through cfg_we_i /
//   cfg_wdata_i; the user must write it only while idle, the block does not
//   enforce this. Reset clears all counters, flags and pointers and sets
//   image_limit to 4; the handle store itself is not cleared and needs no sweep.
`default_nettype none
`include "assert_macros.svh"

module frame_buffer_queue_manager_top #(
  parameter int QUEUE_DEPTH = 8,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire fbqm_pkg::cmd_t        cmd_i,
  output logic                       result_strobe_o,
  output fbqm_pkg::result_t          result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [3:0]            cfg_wdata_i
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = (HANDLE_BITS < fbqm_pkg::HANDLE_W) ? HANDLE_BITS : fbqm_pkg::HANDLE_W;
  localparam int QCAP = (QUEUE_DEPTH < fbqm_pkg::MAX_RESULTS) ? QUEUE_DEPTH
                                                              : fbqm_pkg::MAX_RESULTS;
  localparam int AW = ((IW > fbqm_pkg::COUNT_W) ? IW : fbqm_pkg::COUNT_W) + 1;
  localparam logic [AW-1:0] DEPTH_W = AW'(QUEUE_DEPTH);
  localparam logic [fbqm_pkg::COUNT_W-1:0] CAP_W = fbqm_pkg::COUNT_W'(QCAP);

  fbqm_pkg::state_e state_q, state_d;
  fbqm_pkg::op_e    op_q, op_d;
  fbqm_pkg::kind_e  kind_q, kind_d;
  logic [SW-1:0]    hnd_q, hnd_d;
  logic [SW-1:0]    out_hnd_q, out_hnd_d;
  logic             on_q, on_d;

  logic [IW-1:0]                   head_q, head_d;
  logic [IW-1:0]                   ptr_q, ptr_d;
  logic [fbqm_pkg::COUNT_W-1:0]    q_q, q_d;
  logic [fbqm_pkg::COUNT_W-1:0]    p_q, p_d;
  logic [fbqm_pkg::COUNT_W-1:0]    h_q, h_d;
  logic [fbqm_pkg::COUNT_W-1:0]    pcnt_q, pcnt_d;
  logic [fbqm_pkg::COUNT_W-1:0]    limit_q;
  logic                            lis_q, lis_d;
  logic                            cl_q, cl_d;
  logic                            dp_q, dp_d;
  logic                            grant_q, grant_d;
  logic                            posted_q, posted_d;
  logic [fbqm_pkg::TOTAL_W-1:0]    sc_q, sc_d;
  logic [fbqm_pkg::TOTAL_W-1:0]    dc_q, dc_d;

  // shared modular pointer adder
  logic [IW-1:0]                add_a;
  logic [fbqm_pkg::COUNT_W-1:0] add_b;
  logic [AW-1:0]                add_sum;
  logic [IW-1:0]                add_y;

  logic          st_we;
  logic          st_re;
  logic [SW-1:0] st_rdata;

  logic [fbqm_pkg::COUNT_W-1:0] lim;
  logic [fbqm_pkg::COUNT_W:0]   qh_sum;

  assign lim     = (limit_q > CAP_W) ? CAP_W : limit_q;
  assign qh_sum  = {1'b0, q_q} + {1'b0, h_q};
  assign add_sum = AW'(add_a) + AW'(add_b);
  assign add_y   = (add_sum >= DEPTH_W) ? IW'(add_sum - DEPTH_W) : IW'(add_sum);

  function automatic logic post_ok(input logic lis, input logic dp, input logic cl,
                                   input logic [fbqm_pkg::COUNT_W-1:0] q,
                                   input logic [fbqm_pkg::COUNT_W-1:0] p);
    return lis && !dp && !cl && (q > p);
  endfunction

  always_comb begin
    logic [fbqm_pkg::COUNT_W-1:0] npop;
    logic [fbqm_pkg::COUNT_W-1:0] p_dec;

    npop      = '0;
    p_dec     = (p_q != '0) ? p_q - 4'd1 : p_q;
    state_d   = state_q;
    op_d      = op_q;
    kind_d    = kind_q;
    hnd_d     = hnd_q;
    out_hnd_d = out_hnd_q;
    on_d      = on_q;
    head_d    = head_q;
    ptr_d     = ptr_q;
    q_d       = q_q;
    p_d       = p_q;
    h_d       = h_q;
    pcnt_d    = pcnt_q;
    lis_d     = lis_q;
    cl_d      = cl_q;
    dp_d      = dp_q;
    grant_d   = grant_q;
    posted_d  = posted_q;
    sc_d      = sc_q;
    dc_d      = dc_q;
    add_a     = head_q;
    add_b     = q_q;
    st_we     = 1'b0;
    st_re     = 1'b0;

    unique case (state_q)
      fbqm_pkg::ST_IDLE: begin
        if (start) begin
          op_d    = fbqm_pkg::op_e'(cmd_i.operation);
          hnd_d   = cmd_i.buffer_handle[SW-1:0];
          on_d    = cmd_i.listener_on;
          state_d = fbqm_pkg::ST_DECIDE;
        end
      end

      fbqm_pkg::ST_DECIDE: begin
        posted_d  = 1'b0;
        out_hnd_d = '0;
        kind_d    = fbqm_pkg::KIND_ACK;
        ptr_d     = head_q;
        state_d   = fbqm_pkg::ST_SINGLE;
        unique case (op_q) inside
          fbqm_pkg::OP_SUBMIT: begin
            if (sc_q != '1) sc_d = sc_q + 32'd1;
            if (cl_q || (qh_sum >= {1'b0, lim})) begin
              if (dc_q != '1) dc_d = dc_q + 32'd1;
              kind_d    = fbqm_pkg::KIND_HANDED_BACK;
              out_hnd_d = hnd_q;
            end else begin
              st_we = 1'b1;  // slot head + queued, from the shared adder
              q_d   = q_q + 4'd1;
              if (post_ok(lis_q, dp_q, cl_q, q_d, p_q)) begin
                dp_d     = 1'b1;
                posted_d = 1'b1;
              end
            end
          end
          fbqm_pkg::OP_ACQUIRE, fbqm_pkg::OP_LATEST: begin
            if (h_q >= lim) begin
              kind_d = fbqm_pkg::KIND_AT_LIMIT;
            end else if (q_q != '0) begin
              npop    = (op_q == fbqm_pkg::OP_LATEST) ? q_q : 4'd1;
              add_b   = npop;
              head_d  = add_y;
              q_d     = q_q - npop;
              h_d     = h_q + 4'd1;
              p_d     = (p_dec > q_d) ? q_d : p_dec;
              pcnt_d  = npop;
              grant_d = 1'b1;
              state_d = fbqm_pkg::ST_POP_RD;
              if (post_ok(lis_q, dp_q, cl_q, q_d, p_d)) begin
                dp_d     = 1'b1;
                posted_d = 1'b1;
              end
            end else begin
              kind_d = fbqm_pkg::KIND_EMPTY;
              p_d    = '0;
            end
          end
          fbqm_pkg::OP_RELEASE: begin
            if (h_q != '0) begin
              h_d       = h_q - 4'd1;
              kind_d    = fbqm_pkg::KIND_HANDED_BACK;
              out_hnd_d = hnd_q;
            end
          end
          fbqm_pkg::OP_DELIVER: begin
            dp_d = 1'b0;
            if (!cl_q && lis_q && (q_q > p_q)) begin
              p_d    = p_q + 4'd1;
              kind_d = fbqm_pkg::KIND_FIRE;
            end
            if (post_ok(lis_q, 1'b0, cl_q, q_q, p_d)) begin
              dp_d     = 1'b1;
              posted_d = 1'b1;
            end
          end
          fbqm_pkg::OP_CLAIM: begin
            if (!cl_q && (q_q != '0)) begin
              kind_d = fbqm_pkg::KIND_CLAIM_YES;
            end else begin
              p_d    = p_dec;
              kind_d = fbqm_pkg::KIND_CLAIM_NO;
            end
          end
          fbqm_pkg::OP_LISTENER: begin
            lis_d = on_q;
            if (post_ok(on_q, dp_q, cl_q, q_q, p_q)) begin
              dp_d     = 1'b1;
              posted_d = 1'b1;
            end
          end
          fbqm_pkg::OP_CLOSE: begin
            cl_d   = 1'b1;
            lis_d  = 1'b0;
            head_d = '0;
            if (q_q != '0) begin
              pcnt_d  = q_q;
              grant_d = 1'b0;
              q_d     = '0;
              state_d = fbqm_pkg::ST_POP_RD;
            end
          end
          default: ;
        endcase
      end

      fbqm_pkg::ST_POP_RD: begin
        st_re   = 1'b1;
        add_a   = ptr_q;
        add_b   = 4'd1;
        ptr_d   = add_y;
        state_d = fbqm_pkg::ST_POP_OUT;
      end

      fbqm_pkg::ST_POP_OUT: begin
        pcnt_d  = pcnt_q - 4'd1;
        state_d = (pcnt_q == 4'd1) ? fbqm_pkg::ST_IDLE : fbqm_pkg::ST_POP_RD;
      end

      fbqm_pkg::ST_SINGLE: begin
        state_d = fbqm_pkg::ST_IDLE;
      end

      default: state_d = fbqm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fbqm_pkg::ST_IDLE;
      head_q   <= '0;
      ptr_q    <= '0;
      q_q      <= '0;
      p_q      <= '0;
      h_q      <= '0;
      pcnt_q   <= '0;
      limit_q  <= fbqm_pkg::LIMIT_RESET;
      lis_q    <= 1'b0;
      cl_q     <= 1'b0;
      dp_q     <= 1'b0;
      grant_q  <= 1'b0;
      posted_q <= 1'b0;
      sc_q     <= '0;
      dc_q     <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      ptr_q    <= ptr_d;
      q_q      <= q_d;
      p_q      <= p_d;
      h_q      <= h_d;
      pcnt_q   <= pcnt_d;
      lis_q    <= lis_d;
      cl_q     <= cl_d;
      dp_q     <= dp_d;
      grant_q  <= grant_d;
      posted_q <= posted_d;
      sc_q     <= sc_d;
      dc_q     <= dc_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // command and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    hnd_q     <= hnd_d;
    on_q      <= on_d;
    kind_q    <= kind_d;
    out_hnd_q <= out_hnd_d;
  end

  fbqm_store #(
    .DEPTH  (QUEUE_DEPTH),
    .IDX_W  (IW),
    .DATA_W (SW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (add_y),
    .wdata_i (hnd_q),
    .re_i    (st_re),
    .raddr_i (ptr_q),
    .rdata_o (st_rdata)
  );

  logic pop_out;
  logic pop_rd;
  assign pop_out = (state_q == fbqm_pkg::ST_POP_OUT);
  assign pop_rd  = (state_q == fbqm_pkg::ST_POP_RD);

  assign busy            = (state_q != fbqm_pkg::ST_IDLE);
  assign result_strobe_o = pop_out || (state_q == fbqm_pkg::ST_SINGLE);

  always_comb begin
    result_o = '0;
    if (pop_out) begin
      // the grant of an acquire is the last entry walked
      result_o.kind       = (grant_q && (pcnt_q == 4'd1)) ? fbqm_pkg::KIND_GRANTED
                                                          : fbqm_pkg::KIND_HANDED_BACK;
      result_o.out_handle = fbqm_pkg::HANDLE_W'(st_rdata);
      result_o.last       = (pcnt_q == 4'd1);
    end else begin
      result_o.kind       = kind_q;
      result_o.out_handle = fbqm_pkg::HANDLE_W'(out_hnd_q);
      result_o.last       = 1'b1;
    end
    result_o.notify_post     = posted_q;
    result_o.queued_now      = q_q;
    result_o.promised_now    = p_q;
    result_o.held_now        = h_q;
    result_o.submitted_total = sc_q;
    result_o.dropped_total   = dc_q;
  end

  `FBQM_ASSERT(a_queue_cap, clk_i, rst_ni, q_q <= CAP_W)
  `FBQM_ASSERT_NEXT(a_accept_quiet, clk_i, rst_ni, start && !busy, !result_strobe_o)
  `FBQM_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, result_strobe_o && result_o.last, !busy)
  `FBQM_ASSERT_IMPLY(a_walk_count, clk_i, rst_ni, pop_rd || pop_out, pcnt_q != '0)

endmodule

`default_nettype wire

@@ tb/tb_frame_buffer_queue_manager_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for frame_buffer_queue_manager_top: directed and random commands
// run against a cycle-free predictor of the queue, budget and notification logic.
// Depends on fbqm_pkg and the block's RTL only.

class frame_queue_tracker;
  logic [fbqm_pkg::HANDLE_W-1:0] slot_handle [8];
  bit [2:0]    head;
  int unsigned queued, promised, held;
  bit          listener, closed, pending;
  bit [31:0]   submits, drops;
  bit [3:0]    limit_reg;
  fbqm_pkg::result_t awaited_words [$];
  int unsigned mismatches;

  function new();
    head = 0; queued = 0; promised = 0; held = 0;
    listener = 0; closed = 0; pending = 0;
    submits = 0; drops = 0; limit_reg = fbqm_pkg::LIMIT_RESET;
    mismatches = 0;
  endfunction

  function void set_limit(bit [3:0] v);
    limit_reg = v;
  endfunction

  function int unsigned outstanding();
    return awaited_words.size();
  endfunction

  function int unsigned failures();
    return mismatches + awaited_words.size();
  endfunction

  function logic [fbqm_pkg::HANDLE_W-1:0] pop_head();
    logic [fbqm_pkg::HANDLE_W-1:0] h;
    h = slot_handle[head];
    head = head + 3'd1;
    queued--;
    return h;
  endfunction

  // schedule a delivery if the listener can take one
  function bit post_if_ready();
    if (!listener || pending || closed) return 1'b0;
    if (queued <= promised) return 1'b0;
    pending = 1'b1;
    return 1'b1;
  endfunction

  function void note_command(fbqm_pkg::cmd_t c);
    fbqm_pkg::op_e                 op;
    fbqm_pkg::kind_e               kinds [$];
    logic [fbqm_pkg::HANDLE_W-1:0] hands [$];
    bit                            posted;
    int unsigned                   lim;
    fbqm_pkg::result_t             w;
    op = fbqm_pkg::op_e'(c.operation);
    posted = 1'b0;
    lim = (limit_reg > 8) ? 8 : limit_reg;
    case (op) inside
      fbqm_pkg::OP_SUBMIT: begin
        if (submits != '1) submits++;
        if (closed || queued + held >= lim) begin
          if (drops != '1) drops++;
          kinds.push_back(fbqm_pkg::KIND_HANDED_BACK); hands.push_back(c.buffer_handle);
        end else begin
          slot_handle[(head + queued) % 8] = c.buffer_handle;
          queued++;
          posted = post_if_ready();
          kinds.push_back(fbqm_pkg::KIND_ACK); hands.push_back('0);
        end
      end
      fbqm_pkg::OP_ACQUIRE, fbqm_pkg::OP_LATEST: begin
        if (held >= lim) begin
          kinds.push_back(fbqm_pkg::KIND_AT_LIMIT); hands.push_back('0);
        end else begin
          if (op == fbqm_pkg::OP_LATEST)
            while (queued > 1) begin
              kinds.push_back(fbqm_pkg::KIND_HANDED_BACK); hands.push_back(pop_head());
            end
          if (queued > 0) begin
            hands.push_back(pop_head());
            kinds.push_back(fbqm_pkg::KIND_GRANTED);
            held++;
            if (promised > 0) promised--;
          end else begin
            kinds.push_back(fbqm_pkg::KIND_EMPTY); hands.push_back('0);
          end
          if (promised > queued) promised = queued;
          posted = post_if_ready();
        end
      end
      fbqm_pkg::OP_RELEASE: begin
        if (held > 0) begin
          held--;
          kinds.push_back(fbqm_pkg::KIND_HANDED_BACK); hands.push_back(c.buffer_handle);
        end else begin
          kinds.push_back(fbqm_pkg::KIND_ACK); hands.push_back('0);
        end
      end
      fbqm_pkg::OP_DELIVER: begin
        pending = 1'b0;
        if (!closed && listener && queued > promised) begin
          promised++;
          kinds.push_back(fbqm_pkg::KIND_FIRE);
        end else begin
          kinds.push_back(fbqm_pkg::KIND_ACK);
        end
        hands.push_back('0);
        posted = post_if_ready();
      end
      fbqm_pkg::OP_CLAIM: begin
        if (!closed && queued > 0) begin
          kinds.push_back(fbqm_pkg::KIND_CLAIM_YES);
        end else begin
          if (promised > 0) promised--;
          kinds.push_back(fbqm_pkg::KIND_CLAIM_NO);
        end
        hands.push_back('0);
      end
      fbqm_pkg::OP_LISTENER: begin
        listener = c.listener_on;
        if (c.listener_on && queued > 0) posted = post_if_ready();
        kinds.push_back(fbqm_pkg::KIND_ACK); hands.push_back('0);
      end
      default: begin
        closed = 1'b1;
        listener = 1'b0;
        if (queued == 0) begin
          kinds.push_back(fbqm_pkg::KIND_ACK); hands.push_back('0);
        end
        while (queued > 0) begin
          kinds.push_back(fbqm_pkg::KIND_HANDED_BACK); hands.push_back(pop_head());
        end
        head = 0;
      end
    endcase
    foreach (kinds[k]) begin
      w.kind            = kinds[k];
      w.out_handle      = hands[k];
      w.notify_post     = posted;
      w.queued_now      = fbqm_pkg::COUNT_W'(queued);
      w.promised_now    = fbqm_pkg::COUNT_W'(promised);
      w.held_now        = fbqm_pkg::COUNT_W'(held);
      w.submitted_total = submits;
      w.dropped_total   = drops;
      w.last            = (k == kinds.size() - 1);
      awaited_words.push_back(w);
    end
  endfunction

  function void show(string tag, fbqm_pkg::result_t r);
    $display("  %s kind=%0d handle=%h post=%0d q=%0d p=%0d held=%0d sub=%0d drop=%0d last=%0d",
             tag, r.kind, r.out_handle, r.notify_post, r.queued_now, r.promised_now,
             r.held_now, r.submitted_total, r.dropped_total, r.last);
  endfunction

  function void check_word(fbqm_pkg::result_t got);
    fbqm_pkg::result_t exp_w;
    bit                bad;
    if (awaited_words.size() == 0) begin
      if (mismatches < 10) begin
        $display("result word with nothing awaited");
        show("got", got);
      end
      mismatches++;
      return;
    end
    exp_w = awaited_words.pop_front();
    bad = (got.kind !== exp_w.kind) || (got.out_handle !== exp_w.out_handle) ||
          (got.notify_post !== exp_w.notify_post) ||
          (got.queued_now !== exp_w.queued_now) ||
          (got.promised_now !== exp_w.promised_now) ||
          (got.held_now !== exp_w.held_now) ||
          (got.submitted_total !== exp_w.submitted_total) ||
          (got.dropped_total !== exp_w.dropped_total) ||
          (got.last !== exp_w.last);
    if (bad) begin
      if (mismatches < 10) begin
        $display("result word mismatch");
        show("exp", exp_w);
        show("got", got);
      end
      mismatches++;
    end
  endfunction
endclass

module tb_frame_buffer_queue_manager_top;
  localparam int QUIET_LIMIT = 1000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  fbqm_pkg::cmd_t    cmd_i;
  logic              result_strobe_o;
  fbqm_pkg::result_t result_o;
  logic              cfg_we_i;
  logic [3:0]        cfg_wdata_i;

  frame_queue_tracker tracker;
  int unsigned        quiet_cycles;

  int unsigned phase_limit [6] = '{8, 1, 15, 3, 6, 2};
  int unsigned phase_idle  [6] = '{0, 53, 0, 10, 53, 0};

  frame_buffer_queue_manager_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // command and result words are both taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.note_command(cmd_i);
      if (result_strobe_o) tracker.check_word(result_o);
      quiet_cycles <= ((start && !busy) || result_strobe_o) ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic fbqm_pkg::cmd_t make_cmd(fbqm_pkg::op_e op,
                                              logic [fbqm_pkg::HANDLE_W-1:0] h, logic on);
    fbqm_pkg::cmd_t c;
    c.operation = op;
    c.buffer_handle = h;
    c.listener_on = on;
    return c;
  endfunction

  function automatic fbqm_pkg::cmd_t pick_cmd(bit allow_close);
    int unsigned   r;
    fbqm_pkg::op_e op;
    r = $urandom_range(99);
    if (r < 32)      op = fbqm_pkg::OP_SUBMIT;
    else if (r < 46) op = fbqm_pkg::OP_ACQUIRE;
    else if (r < 54) op = fbqm_pkg::OP_LATEST;
    else if (r < 66) op = fbqm_pkg::OP_RELEASE;
    else if (r < 78) op = fbqm_pkg::OP_DELIVER;
    else if (r < 86) op = fbqm_pkg::OP_CLAIM;
    else if (r < 96) op = fbqm_pkg::OP_LISTENER;
    else             op = allow_close ? fbqm_pkg::OP_CLOSE : fbqm_pkg::OP_SUBMIT;
    return make_cmd(op, fbqm_pkg::HANDLE_W'($urandom_range(16'hFFFF)),
                    $urandom_range(3) != 0);
  endfunction

  // present a word at the falling edge and hold it until the block takes it
  task automatic send_word(fbqm_pkg::cmd_t c, int unsigned idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send(fbqm_pkg::op_e op, logic [fbqm_pkg::HANDLE_W-1:0] h = '0,
                      logic on = 1'b0);
    send_word(make_cmd(op, h, on), 0);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_limit(v);
  endtask

  task automatic random_run(int unsigned n, int unsigned idle_pct, bit allow_close);
    repeat (n) begin
      // now and then let the queue drain completely before going on
      if ($urandom_range(39) == 0) settle();
      send_word(pick_cmd(allow_close), idle_pct);
    end
  endtask

  initial begin
    tracker      = new();
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle block: nothing held, nothing queued, no delivery pending
    send(fbqm_pkg::OP_RELEASE, 16'h0000);
    send(fbqm_pkg::OP_ACQUIRE);
    send(fbqm_pkg::OP_CLAIM);
    send(fbqm_pkg::OP_DELIVER);
    send(fbqm_pkg::OP_LISTENER, 16'h0000, 1'b1);
    send(fbqm_pkg::OP_SUBMIT, 16'hFFFF);
    send(fbqm_pkg::OP_SUBMIT, 16'h0000);
    send(fbqm_pkg::OP_DELIVER);
    send(fbqm_pkg::OP_CLAIM);
    send(fbqm_pkg::OP_ACQUIRE);
    send(fbqm_pkg::OP_SUBMIT, 16'h1357);
    send(fbqm_pkg::OP_SUBMIT, 16'h2468);
    send(fbqm_pkg::OP_SUBMIT, 16'hBEEF);           // budget reached: dropped
    send(fbqm_pkg::OP_LATEST);
    send(fbqm_pkg::OP_RELEASE, 16'hFFFF);
    send(fbqm_pkg::OP_RELEASE, 16'h2468);
    send(fbqm_pkg::OP_LISTENER, 16'hFFFF, 1'b0);

    // zero budget: every submit dropped, every acquire refused
    write_limit(4'd0);
    send(fbqm_pkg::OP_SUBMIT, 16'hABCD);
    send(fbqm_pkg::OP_ACQUIRE);
    send(fbqm_pkg::OP_LATEST);

    foreach (phase_limit[i]) begin
      write_limit(4'(phase_limit[i]));
      random_run(38, phase_idle[i], 1'b0);
    end

    // close flushes the queue; the block stays closed for the rest of the run
    write_limit(4'd8);
    send(fbqm_pkg::OP_LISTENER, 16'h0000, 1'b1);
    send(fbqm_pkg::OP_SUBMIT, 16'h0F0F);
    send(fbqm_pkg::OP_SUBMIT, 16'hF0F0);
    send(fbqm_pkg::OP_SUBMIT, 16'h55AA);
    send(fbqm_pkg::OP_CLOSE);
    send(fbqm_pkg::OP_CLOSE);
    send(fbqm_pkg::OP_LISTENER, 16'h0000, 1'b1);
    send(fbqm_pkg::OP_DELIVER);
    send(fbqm_pkg::OP_SUBMIT, 16'h7777);
    send(fbqm_pkg::OP_CLAIM);
    random_run(20, 10, 1'b1);

    settle();
    if (tracker.failures() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
